>>> rtl/core/spfa_pkg.sv
// Shared constants and controller/datapath command and status types for the frame averager.
`timescale 1ns / 1ps

package spfa_pkg;

  localparam int unsigned ELEMENTS_DFLT  = 54;
  localparam int unsigned AVG_DEPTH_DFLT = 4;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VAL_W      = 12;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned SLOT_MAX_W = 4;

  localparam logic [BYTE_W-1:0] ID_BASE     = 8'h3d;
  localparam logic [BYTE_W-1:0] MARKER_OK   = 8'h01;
  localparam logic [BYTE_W-1:0] END_OK      = 8'h00;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;
  localparam logic [VAL_W-1:0]  FULL_SCALE  = 12'hfff;

  typedef struct packed {
    logic                  accept;
    logic                  cur_rd;
    logic                  hist_wr;
    logic                  hist_rd;
    logic                  acc_clr;
    logic                  acc_add;
    logic                  mul;
    logic                  load;
    logic                  load_avg;
    logic [IDX_W-1:0]      elem;
    logic [SLOT_MAX_W-1:0] rd_slot;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic avg_en;
  } sts_t;

endpackage

>>> rtl/core/spfa_if.sv
// Packet input and element output channel interfaces.
`timescale 1ns / 1ps

interface spfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [spfa_pkg::BYTE_W-1:0] id_byte;
  logic [spfa_pkg::BYTE_W-1:0] marker_byte;
  logic [spfa_pkg::BYTE_W-1:0] value_high;
  logic [spfa_pkg::BYTE_W-1:0] value_low;
  logic [spfa_pkg::BYTE_W-1:0] end_byte;

  modport source (
    output valid, id_byte, marker_byte, value_high, value_low, end_byte,
    input  ready
  );
  modport sink (
    input  valid, id_byte, marker_byte, value_high, value_low, end_byte,
    output ready
  );
endinterface

interface spfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [spfa_pkg::IDX_W-1:0] element_index;
  logic [spfa_pkg::VAL_W-1:0] element_value;
  logic                       last;

  modport source (
    output valid, element_index, element_value, last,
    input  ready
  );
  modport sink (
    input  valid, element_index, element_value, last,
    output ready
  );
endinterface

>>> rtl/core/spfa_ctrl.sv
// Sequencer for packet acceptance and per-element frame emission.
`timescale 1ns / 1ps

module spfa_ctrl #(
  parameter int unsigned ELEMENTS  = spfa_pkg::ELEMENTS_DFLT,
  parameter int unsigned AVG_DEPTH = spfa_pkg::AVG_DEPTH_DFLT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  spfa_pkg::sts_t  sts,
  output spfa_pkg::cmd_t  cmd
);

  localparam int unsigned CurAw = $clog2(ELEMENTS);
  localparam int unsigned SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  typedef enum logic [2:0] {
    IDLE,
    RD_CUR,
    WR_HIST,
    RD_HIST,
    ACC_LAST,
    MUL,
    LOAD
  } state_t;

  state_t            state_r, state_nxt;
  logic [CurAw-1:0]  elem_r, elem_nxt;
  logic [SlotW-1:0]  slot_j_r, slot_j_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              accept;
  logic              out_free;

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_vld_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_vld_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    elem_nxt    = elem_r;
    slot_j_nxt  = slot_j_r;
    out_vld_nxt = (out_vld_r && out_ready) ? 1'b0 : out_vld_r;

    cmd          = '0;
    cmd.accept   = accept;
    cmd.elem     = spfa_pkg::IDX_W'(elem_r);
    cmd.rd_slot  = spfa_pkg::SLOT_MAX_W'(slot_j_r);
    cmd.load_avg = sts.avg_en;

    unique case (state_r)
      IDLE: begin
        if (accept && sts.push) begin
          elem_nxt  = '0;
          state_nxt = RD_CUR;
        end
      end
      RD_CUR: begin
        cmd.cur_rd = 1'b1;
        state_nxt  = WR_HIST;
      end
      WR_HIST: begin
        cmd.hist_wr = 1'b1;
        cmd.acc_clr = 1'b1;
        slot_j_nxt  = '0;
        state_nxt   = sts.avg_en ? RD_HIST : LOAD;
      end
      RD_HIST: begin
        cmd.hist_rd = 1'b1;
        // data of the previous read lands now
        cmd.acc_add = (slot_j_r != '0);
        if (slot_j_r == SlotW'(AVG_DEPTH - 1)) begin
          state_nxt = ACC_LAST;
        end else begin
          slot_j_nxt = slot_j_r + 1'b1;
        end
      end
      ACC_LAST: begin
        cmd.acc_add = 1'b1;
        state_nxt   = MUL;
      end
      MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = LOAD;
      end
      LOAD: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load    = 1'b1;
          out_vld_nxt = 1'b1;
          if (elem_r == CurAw'(ELEMENTS - 1)) begin
            state_nxt = IDLE;
          end else begin
            elem_nxt  = elem_r + 1'b1;
            state_nxt = RD_CUR;
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      elem_r    <= '0;
      slot_j_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      elem_r    <= elem_nxt;
      slot_j_r  <= slot_j_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

>>> rtl/core/spfa_dp.sv
// Packet check, frame and history memories, ring accumulation and output register.
`timescale 1ns / 1ps

module spfa_dp #(
  parameter int unsigned ELEMENTS  = spfa_pkg::ELEMENTS_DFLT,
  parameter int unsigned AVG_DEPTH = spfa_pkg::AVG_DEPTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [spfa_pkg::BYTE_W-1:0]   in_id_byte,
  input  logic [spfa_pkg::BYTE_W-1:0]   in_marker_byte,
  input  logic [spfa_pkg::BYTE_W-1:0]   in_value_high,
  input  logic [spfa_pkg::BYTE_W-1:0]   in_value_low,
  input  logic [spfa_pkg::BYTE_W-1:0]   in_end_byte,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  spfa_pkg::cmd_t                cmd,
  output spfa_pkg::sts_t                sts,
  output logic [spfa_pkg::IDX_W-1:0]    out_element_index,
  output logic [spfa_pkg::VAL_W-1:0]    out_element_value,
  output logic                          out_last
);

  localparam int unsigned VW         = spfa_pkg::VAL_W;
  localparam int unsigned CurAw      = $clog2(ELEMENTS);
  localparam int unsigned SlotW      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned HistDepth  = AVG_DEPTH * ELEMENTS;
  localparam int unsigned HistAw     = $clog2(HistDepth);
  localparam int unsigned RunW       = $clog2(ELEMENTS + 2);
  localparam int unsigned SumW       = VW + $clog2(AVG_DEPTH);
  // exact floor division of a SumW-bit sum by AVG_DEPTH via rounded-up reciprocal
  localparam int unsigned RecipShift = SumW + $clog2(AVG_DEPTH);
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam longint unsigned RecipL =
    ((64'd1 << RecipShift) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam int unsigned ProdW      = SumW + RecipW;

  logic [VW-1:0]     cur_mem  [ELEMENTS];
  logic [VW-1:0]     hist_mem [HistDepth];

  logic [VW-1:0]     cur_q_r;
  logic [VW-1:0]     hist_q_r;
  logic              rd_vld_r;
  logic [SumW-1:0]   acc_r;
  logic [ProdW-1:0]  prod_r;

  logic [SlotW-1:0]     slot_r, slot_nxt;
  logic [AVG_DEPTH-1:0] row_vld_r;
  logic [CurAw-1:0]     prev_r;
  logic [RunW-1:0]      run_r, run_nxt;
  logic                 avg_en_r;

  logic [spfa_pkg::BYTE_W-1:0] id_off;
  logic [CurAw-1:0]            idx, exp_idx, elem;
  logic [SlotW-1:0]            rd_slot;
  logic                        pkt_ok, pkt_wr;
  logic [VW-1:0]               reading;
  logic [HistAw-1:0]           hist_wa, hist_ra;

  // ids below the base wrap to a large offset and fail the range test too
  assign id_off  = in_id_byte - spfa_pkg::ID_BASE;
  assign idx     = id_off[CurAw-1:0];
  assign pkt_ok  = (id_off < spfa_pkg::BYTE_W'(ELEMENTS))
                && (in_marker_byte == spfa_pkg::MARKER_OK)
                && (in_end_byte == spfa_pkg::END_OK);
  assign pkt_wr  = cmd.accept && pkt_ok;
  assign reading = spfa_pkg::FULL_SCALE
                 - {in_value_high[3:0] & spfa_pkg::NIBBLE_MASK[3:0], in_value_low};

  assign exp_idx = (prev_r == CurAw'(ELEMENTS - 1)) ? '0 : prev_r + 1'b1;

  always_comb begin
    if (idx != exp_idx) begin
      run_nxt = '0;
    end else if (run_r < RunW'(ELEMENTS + 1)) begin
      run_nxt = run_r + 1'b1;
    end else begin
      run_nxt = run_r;
    end
  end

  assign slot_nxt   = (slot_r == SlotW'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign sts.push   = pkt_ok && (run_nxt > RunW'(ELEMENTS))
                   && (idx == CurAw'(ELEMENTS - 1));
  assign sts.avg_en = avg_en_r;

  assign elem    = cmd.elem[CurAw-1:0];
  assign rd_slot = cmd.rd_slot[SlotW-1:0];
  assign hist_wa = HistAw'(slot_r) * HistAw'(ELEMENTS) + HistAw'(elem);
  assign hist_ra = HistAw'(rd_slot) * HistAw'(ELEMENTS) + HistAw'(elem);

  always_ff @(posedge clk) begin
    if (pkt_wr) begin
      cur_mem[idx] <= reading;
    end
    if (cmd.cur_rd) begin
      cur_q_r <= cur_mem[elem];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[hist_wa] <= cur_q_r;
    end
    if (cmd.hist_rd) begin
      hist_q_r <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      row_vld_r <= '0;
      prev_r    <= '0;
      run_r     <= '0;
      avg_en_r  <= 1'b1;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        avg_en_r <= cfg_wdata;
      end
      if (pkt_wr) begin
        prev_r <= idx;
        run_r  <= run_nxt;
        // advance the ring before the frame copy lands in the new slot
        if (sts.push) begin
          slot_r              <= slot_nxt;
          row_vld_r[slot_nxt] <= 1'b1;
        end
      end
      if (cmd.hist_rd) begin
        rd_vld_r <= row_vld_r[rd_slot];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + (rd_vld_r ? SumW'(hist_q_r) : '0);
    end
    if (cmd.mul) begin
      prod_r <= ProdW'(acc_r) * ProdW'(Recip);
    end
    if (cmd.load) begin
      out_element_index <= spfa_pkg::IDX_W'(elem);
      out_element_value <= cmd.load_avg ? prod_r[RecipShift +: VW] : cur_q_r;
      out_last          <= (elem == CurAw'(ELEMENTS - 1));
    end
  end

endmodule

>>> rtl/core/sensor_packet_frame_averager.sv
// Non-final packets are taken without leaving idle; in_ready stays high between frames.
// A frame-end packet emits ELEMENTS beats; each steps through RD_CUR, WR_HIST, RD_HIST, ACC_LAST, MUL
// and LOAD with averaging on, or RD_CUR, WR_HIST and LOAD with it off, bounded by one history memory read per cycle.
// An output register holds each beat, so the next element computes while it waits.
// Reset (rst_n low, synchronous) clears control and the history ring's valid flags, and sets averaging on.
`timescale 1ns / 1ps

module sensor_packet_frame_averager #(
  parameter int unsigned ELEMENTS  = spfa_pkg::ELEMENTS_DFLT,
  parameter int unsigned AVG_DEPTH = spfa_pkg::AVG_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  spfa_in_if.sink    in_if,
  spfa_out_if.source out_if,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  spfa_pkg::cmd_t cmd;
  spfa_pkg::sts_t sts;

  spfa_ctrl #(
    .ELEMENTS  (ELEMENTS),
    .AVG_DEPTH (AVG_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spfa_dp #(
    .ELEMENTS  (ELEMENTS),
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_id_byte        (in_if.id_byte),
    .in_marker_byte    (in_if.marker_byte),
    .in_value_high     (in_if.value_high),
    .in_value_low      (in_if.value_low),
    .in_end_byte       (in_if.end_byte),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_element_index (out_if.element_index),
    .out_element_value (out_if.element_value),
    .out_last          (out_if.last)
  );

endmodule

>>> rtl/core/spfa_checker.sv
// Port-level checks for the frame averager, bound to the top level.
`timescale 1ns / 1ps

module spfa_checker #(
  parameter int unsigned ELEMENTS = spfa_pkg::ELEMENTS_DFLT
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [spfa_pkg::IDX_W-1:0] out_element_index,
  input logic                       out_last
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element_index))
    else $error("stalled output beat dropped or changed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_element_index == spfa_pkg::IDX_W'(ELEMENTS - 1))))
    else $error("last flag does not match final element");

  a_busy_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("packet accepted in the middle of a frame emission");

endmodule

bind sensor_packet_frame_averager spfa_checker #(
  .ELEMENTS (ELEMENTS)
) u_spfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_element_index (out_if.element_index),
  .out_last          (out_if.last)
);

>>> sim/sensor_packet_frame_averager_tb.sv
// Self-checking testbench for the tactile packet frame averager.
`timescale 1ns / 1ps

module sensor_packet_frame_averager_tb;

  localparam int unsigned ELEMENTS     = spfa_pkg::ELEMENTS_DFLT;
  localparam int unsigned AVG_DEPTH    = spfa_pkg::AVG_DEPTH_DFLT;
  localparam int unsigned BYTE_W       = spfa_pkg::BYTE_W;
  localparam int unsigned IDX_W        = spfa_pkg::IDX_W;
  localparam int unsigned VAL_W        = spfa_pkg::VAL_W;
  localparam logic [BYTE_W-1:0] ID_BASE    = spfa_pkg::ID_BASE;
  localparam logic [BYTE_W-1:0] MARKER_OK  = spfa_pkg::MARKER_OK;
  localparam logic [BYTE_W-1:0] END_OK     = spfa_pkg::END_OK;
  localparam logic [VAL_W-1:0]  FULL_SCALE = spfa_pkg::FULL_SCALE;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          HOLD_AT_BEAT = 20;
  localparam logic        KNOWN_SILENT = 1'b1;
  localparam logic        ASK_MODEL    = 1'b0;
  localparam int          N_DIRECTED   = 22;

  typedef struct packed {
    logic [BYTE_W-1:0] id_byte;
    logic [BYTE_W-1:0] marker_byte;
    logic [BYTE_W-1:0] value_high;
    logic [BYTE_W-1:0] value_low;
    logic [BYTE_W-1:0] end_byte;
  } packet_t;

  typedef struct packed {
    packet_t pkt;
    logic    silent;
  } row_t;

  typedef struct packed {
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] element_value;
    logic             last;
  } element_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  spfa_in_if  in_if ();
  spfa_out_if out_if ();

  sensor_packet_frame_averager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Mirror of the block state
  logic [VAL_W-1:0] live_frame [ELEMENTS];
  logic [VAL_W-1:0] frame_ring [AVG_DEPTH][ELEMENTS];
  int unsigned      ring_slot;
  int unsigned      last_index;
  int unsigned      run_length;
  logic             averaging_on;

  element_t pending_elements[$];
  int       error_count = 0;
  int       beats_seen  = 0;
  int       burst_left  = 0;

  row_t directed_rows [N_DIRECTED] = '{
    '{'{8'h3c, 8'h01, 8'h00, 8'h00, 8'h00}, KNOWN_SILENT},  // one below the id base
    '{'{8'h73, 8'h01, 8'h00, 8'h00, 8'h00}, KNOWN_SILENT},  // one beyond the last element
    '{'{8'h00, 8'h01, 8'hff, 8'hff, 8'h00}, KNOWN_SILENT},
    '{'{8'hff, 8'h01, 8'h0f, 8'hff, 8'h00}, KNOWN_SILENT},
    '{'{8'h3e, 8'h00, 8'h0f, 8'hff, 8'h00}, KNOWN_SILENT},  // bad marker
    '{'{8'h3e, 8'hff, 8'h0f, 8'hff, 8'h00}, KNOWN_SILENT},
    '{'{8'h3e, 8'h01, 8'h0f, 8'hff, 8'h01}, KNOWN_SILENT},  // bad end byte
    '{'{8'h3e, 8'h01, 8'h0f, 8'hff, 8'hff}, KNOWN_SILENT},
    '{'{8'h3e, 8'h01, 8'h0f, 8'hff, 8'h80}, KNOWN_SILENT},
    '{'{8'h3e, 8'h01, 8'h00, 8'h00, 8'h00}, ASK_MODEL},     // element 1, in order
    '{'{8'h3f, 8'h01, 8'hff, 8'hff, 8'h00}, ASK_MODEL},     // upper nibble ignored
    '{'{8'h40, 8'h01, 8'hf0, 8'h00, 8'h00}, ASK_MODEL},
    '{'{8'h41, 8'h01, 8'h08, 8'h00, 8'h00}, ASK_MODEL},
    '{'{8'h72, 8'h01, 8'h00, 8'hff, 8'h00}, ASK_MODEL},     // last element, out of order
    '{'{8'h3d, 8'h01, 8'h5a, 8'ha5, 8'h00}, ASK_MODEL},     // wrap back to element 0
    '{'{8'h3e, 8'h01, 8'ha5, 8'h5a, 8'h00}, ASK_MODEL},
    '{'{8'h3e, 8'h01, 8'h0f, 8'h00, 8'h00}, ASK_MODEL},     // repeat drops the run
    '{'{8'h3d, 8'h01, 8'h00, 8'h01, 8'h00}, ASK_MODEL},
    '{'{8'h3d, 8'h01, 8'h0f, 8'hfe, 8'h00}, ASK_MODEL},
    '{'{8'h3e, 8'h01, 8'h07, 8'hff, 8'h00}, ASK_MODEL},
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'hff}, KNOWN_SILENT},
    '{'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, KNOWN_SILENT}
  };

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void clear_model();
    for (int i = 0; i < ELEMENTS; i++) begin
      live_frame[i] = '0;
      for (int j = 0; j < AVG_DEPTH; j++) frame_ring[j][i] = '0;
    end
    ring_slot    = 0;
    last_index   = 0;
    run_length   = 0;
    averaging_on = 1'b1;
  endfunction

  function automatic int unsigned next_in_order();
    return (last_index < ELEMENTS - 1) ? last_index + 1 : 0;
  endfunction

  // Fold one accepted packet into the mirror; returns the number of beats it emits.
  function automatic int absorb_packet(input packet_t p);
    int unsigned idx;
    int unsigned sum;
    logic [VAL_W-1:0] reading;
    element_t e;
    if (p.id_byte < ID_BASE || int'(p.id_byte) - int'(ID_BASE) >= ELEMENTS) return 0;
    if (p.marker_byte != MARKER_OK || p.end_byte != END_OK) return 0;
    idx = int'(p.id_byte) - int'(ID_BASE);
    reading = {p.value_high[3:0], p.value_low};
    live_frame[idx] = FULL_SCALE - reading;
    if (idx == next_in_order()) begin
      if (run_length < ELEMENTS + 1) run_length++;
    end else begin
      run_length = 0;
    end
    last_index = idx;
    if (run_length <= ELEMENTS || idx != ELEMENTS - 1) return 0;
    ring_slot = (ring_slot + 1) % AVG_DEPTH;
    for (int i = 0; i < ELEMENTS; i++) frame_ring[ring_slot][i] = live_frame[i];
    for (int i = 0; i < ELEMENTS; i++) begin
      sum = 0;
      for (int j = 0; j < AVG_DEPTH; j++) sum += frame_ring[j][i];
      e.element_index = IDX_W'(i);
      e.element_value = averaging_on ? VAL_W'(sum / AVG_DEPTH) : live_frame[i];
      e.last          = (i == ELEMENTS - 1);
      pending_elements.push_back(e);
    end
    return ELEMENTS;
  endfunction

  // Offer one packet, in bursts with random gaps; returns after its beat is taken.
  task automatic send_packet(input packet_t p, output int beats);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.id_byte     <= p.id_byte;
    in_if.marker_byte <= p.marker_byte;
    in_if.value_high  <= p.value_high;
    in_if.value_low   <= p.value_low;
    in_if.end_byte    <= p.end_byte;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats = absorb_packet(p);
  endtask

  function automatic packet_t good_packet(input int unsigned idx);
    packet_t p;
    p.id_byte     = ID_BASE + BYTE_W'(idx);
    p.marker_byte = MARKER_OK;
    p.end_byte    = END_OK;
    p.value_low   = BYTE_W'($urandom);
    p.value_high  = BYTE_W'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        p.value_high[3:0] = 4'h0;
        p.value_low       = 8'h00;
      end
      1: begin
        p.value_high[3:0] = 4'hf;
        p.value_low       = 8'hff;
      end
      default: ;
    endcase
    return p;
  endfunction

  // A packet the block must drop: bad id, bad marker or bad end byte.
  function automatic packet_t noise_packet();
    packet_t p;
    p = good_packet($urandom_range(0, ELEMENTS - 1));
    case ($urandom_range(0, 2))
      0: p.id_byte = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(0, ID_BASE - 1))
                                                 : BYTE_W'($urandom_range(ID_BASE + ELEMENTS,
                                                                          255));
      1: p.marker_byte = MARKER_OK ^ BYTE_W'($urandom_range(1, 255));
      default: p.end_byte = BYTE_W'($urandom_range(1, 255));
    endcase
    return p;
  endfunction

  task automatic run_traffic(input int valid_target);
    int sent;
    int beats;
    int stretch;
    bit first;
    sent  = 0;
    first = 1'b1;
    while (sent < valid_target) begin
      if (first || $urandom_range(0, 9) < 8) begin
        // well-formed stretch, picking up where the last element left off;
        // the opening one is long enough to complete a full frame
        stretch = first ? int'(2 * ELEMENTS + 4) : int'($urandom_range(20, 130));
        first   = 1'b0;
        for (int k = 0; k < stretch && sent < valid_target; k++) begin
          if ($urandom_range(0, 15) == 0) send_packet(noise_packet(), beats);
          send_packet(good_packet(next_in_order()), beats);
          sent++;
        end
      end else begin
        // broken sequence: random elements mixed with garbage
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) send_packet(noise_packet(), beats);
          send_packet(good_packet($urandom_range(0, ELEMENTS - 1)), beats);
          sent++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_averaging(input logic en);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    averaging_on = en;
    cfg_we <= 1'b0;
  endtask

  // Receiver: check each beat, stall on a shifting pattern, one long hold-off
  initial begin
    element_t want;
    int mode;
    int hold_left;
    bit hold_done;
    int tick;
    mode = 0;
    hold_left = 0;
    hold_done = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        beats_seen++;
        if (pending_elements.size() == 0) begin
          report_mismatch("unexpected beat, index", int'(out_if.element_index), -1);
        end else begin
          want = pending_elements.pop_front();
          if (out_if.element_index !== want.element_index)
            report_mismatch("element_index", int'(out_if.element_index),
                            int'(want.element_index));
          if (out_if.element_value !== want.element_value)
            report_mismatch("element_value", int'(out_if.element_value),
                            int'(want.element_value));
          if (out_if.last !== want.last)
            report_mismatch("last", int'(out_if.last), int'(want.last));
        end
      end
      if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 0);
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    int beats;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.id_byte     <= '0;
    in_if.marker_byte <= '0;
    in_if.value_high  <= '0;
    in_if.value_low   <= '0;
    in_if.end_byte    <= '0;
    clear_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_packet(directed_rows[r].pkt, beats);
      if (directed_rows[r].silent == KNOWN_SILENT && beats != 0)
        report_mismatch("beats for dropped packet", beats, 0);
    end

    run_traffic(110);
    write_averaging(1'b0);
    run_traffic(110);
    write_averaging(1'b1);
    run_traffic(110);
    wait_drained();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
